// ===== hdl/utbs_pkg.sv =====
// ----------------------------------------------------------------------------
// utbs_pkg
// Shared types and constants for the upper-triangular back substitution block.
// ----------------------------------------------------------------------------
package utbs_pkg;

    localparam int MAX_UNKNOWNS = 1024;
    localparam int IDX_W        = $clog2(MAX_UNKNOWNS);
    localparam int SIZE_W       = 11;
    localparam int VAL_W        = 32;
    localparam int ACC_W        = 64;
    localparam int QDIG_W       = 34;   // quotient bits kept by the divider

    typedef struct packed {
        logic [9:0]         row_index;
        logic [9:0]         column_index;
        logic signed [31:0] coefficient;
        logic signed [31:0] right_hand_side;
    } in_item_t;

    typedef struct packed {
        logic [9:0]         solved_row;
        logic signed [31:0] solution_value;
        logic               divide_by_zero;
        logic               saturated;
    } out_item_t;

endpackage

// ===== hdl/upper_triangular_back_substitution.sv =====
// ----------------------------------------------------------------------------
// upper_triangular_back_substitution
// Streaming Q16.16 back substitution with a single solution memory.
// ----------------------------------------------------------------------------
// Coefficient items arrive row by row, last row first; the diagonal item closes
// its row. An off-diagonal item is handled in steps: read the stored solution
// of its column from the solution memory (registered read), form the 32x32
// product, then add it into the saturating 64-bit Q32.32 row sum. A diagonal
// item with a non-zero coefficient goes through the restoring divider, which
// yields one quotient bit per cycle over all 64 dividend bits, and then through
// the finishing state for sign, clamp, write back and emit. A diagonal item with
// a zero coefficient goes straight to the finishing state. Items below the
// diagonal or out of range are taken and dropped. One item is in flight at a
// time. A result waits in an output register while new items are still taken;
// only the finishing state of the next diagonal item stalls, for as long as the
// previous result has not been taken. No clearing pass: off-diagonal items must
// name only columns already solved; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module upper_triangular_back_substitution (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  utbs_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utbs_pkg::out_item_t   m_data,
    input  logic                  cfg_we,
    input  logic [10:0]           cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;   // memory data valid, multiply
    localparam logic [2:0] ST_ACC  = 3'd2;   // accumulate product
    localparam logic [2:0] ST_DIV  = 3'd3;   // divider running
    localparam logic [2:0] ST_FIN  = 3'd4;   // sign, clamp, write back, emit

    logic [2:0]  state_reg, state_next;
    logic [utbs_pkg::SIZE_W-1:0] size_reg;
    logic signed [utbs_pkg::ACC_W-1:0] acc_reg;

    // Solution memory
    logic signed [31:0] mem [utbs_pkg::MAX_UNKNOWNS];
    logic signed [31:0] rd_reg;
    logic               wr_en;
    logic [utbs_pkg::IDX_W-1:0] wr_addr;
    logic signed [31:0] wr_data;

    utbs_pkg::in_item_t item_reg;
    logic signed [63:0] prod_reg;

    // Divider
    logic [63:0] num_mag_reg;     // dividend bits, shifted out MSB first
    logic [31:0] den_mag_reg;
    logic [32:0] rem_reg;
    logic [utbs_pkg::QDIG_W-1:0] quo_reg;
    logic        high_reg;        // quotient already beyond kept bits
    logic        neg_reg;
    logic        dz_reg;          // zero diagonal coefficient
    logic [6:0]  cnt_reg;

    utbs_pkg::out_item_t out_reg;
    logic out_valid_reg;

    // Effective size and item classification
    logic [utbs_pkg::SIZE_W-1:0] eff_size;
    logic in_range, is_diag, is_off;
    logic accept;
    logic fin_go;

    assign eff_size = (size_reg > utbs_pkg::SIZE_W'(utbs_pkg::MAX_UNKNOWNS))
                    ? utbs_pkg::SIZE_W'(utbs_pkg::MAX_UNKNOWNS) : size_reg;
    assign in_range = ({1'b0, s_data.row_index} < eff_size)
                   && ({1'b0, s_data.column_index} < eff_size);
    assign is_diag  = in_range && (s_data.column_index == s_data.row_index);
    assign is_off   = in_range && (s_data.column_index > s_data.row_index);

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Finishing cycle waits for a free output register
    assign fin_go  = (state_reg == ST_FIN) && (!out_valid_reg || m_ready);

    // Saturating add of product into sum
    logic signed [63:0] sum_raw;
    logic signed [63:0] sum_sat;
    assign sum_raw = acc_reg + prod_reg;
    always_comb begin
        sum_sat = sum_raw;
        if (!acc_reg[63] && !prod_reg[63] && sum_raw[63])
            sum_sat = {1'b0, {63{1'b1}}};
        else if (acc_reg[63] && prod_reg[63] && !sum_raw[63])
            sum_sat = {1'b1, 63'd0};
    end

    // Numerator: rhs*2^16 - acc, saturated
    logic signed [63:0] rhs_q, num_raw, num_sat;
    assign rhs_q   = {{16{s_data.right_hand_side[31]}}, s_data.right_hand_side, 16'd0};
    assign num_raw = rhs_q - acc_reg;
    always_comb begin
        num_sat = num_raw;
        if (!rhs_q[63] && acc_reg[63] && num_raw[63])
            num_sat = {1'b0, {63{1'b1}}};
        else if (rhs_q[63] && !acc_reg[63] && !num_raw[63])
            num_sat = {1'b1, 63'd0};
    end

    // Divider step
    logic [32:0] rem_sh, rem_sub;
    logic        fits;
    assign rem_sh  = {rem_reg[31:0], num_mag_reg[63]};
    assign rem_sub = rem_sh - {1'b0, den_mag_reg};
    assign fits    = !rem_sub[32];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_off)       state_next = ST_MUL;
                else if (accept && is_diag)
                    state_next = (s_data.coefficient != 0) ? ST_DIV : ST_FIN;
            end
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_IDLE;
            ST_DIV:  if (cnt_reg == 7'd63) state_next = ST_FIN;
            ST_FIN:  if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Final value with clamp
    logic signed [31:0] fin_val;
    logic               fin_sat;
    always_comb begin
        fin_sat = 1'b0;
        fin_val = '0;
        if (dz_reg) begin
            fin_val = '0;
        end else if (neg_reg) begin
            if (high_reg || quo_reg > 34'h080000000) begin
                fin_sat = 1'b1;
                fin_val = 32'sh80000000;
            end else begin
                fin_val = 32'(-$signed({1'b0, quo_reg}));
            end
        end else begin
            if (high_reg || quo_reg > 34'h07FFFFFFF) begin
                fin_sat = 1'b1;
                fin_val = 32'sh7FFFFFFF;
            end else begin
                fin_val = quo_reg[31:0];
            end
        end
    end

    // Memory write port
    always_comb begin
        wr_en   = fin_go;
        wr_addr = item_reg.row_index;
        wr_data = fin_val;
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[s_data.column_index];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            size_reg      <= 11'd1024;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
            if (m_valid && m_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_ACC)
                acc_reg <= sum_sat;
            if (accept && is_diag)
                acc_reg <= '0;
            if (fin_go)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept)
            item_reg <= s_data;
        if (state_reg == ST_MUL)
            prod_reg <= item_reg.coefficient * rd_reg;
        if (accept && is_diag) begin
            num_mag_reg <= num_sat[63] ? 64'(-num_sat) : num_sat;
            den_mag_reg <= s_data.coefficient[31] ? 32'(-s_data.coefficient)
                                                  : s_data.coefficient;
            neg_reg     <= num_sat[63] ^ s_data.coefficient[31];
            dz_reg      <= (s_data.coefficient == 0);
            rem_reg     <= '0;
            quo_reg     <= '0;
            high_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        if (state_reg == ST_DIV) begin
            num_mag_reg <= {num_mag_reg[62:0], 1'b0};
            rem_reg     <= fits ? rem_sub : rem_sh;
            quo_reg     <= {quo_reg[utbs_pkg::QDIG_W-2:0], fits};
            high_reg    <= high_reg | quo_reg[utbs_pkg::QDIG_W-1];
            cnt_reg     <= cnt_reg + 7'd1;
        end
        if (fin_go)
            out_reg <= '{solved_row: item_reg.row_index, solution_value: fin_val,
                         divide_by_zero: dz_reg, saturated: fin_sat};
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the upper-triangular back substitution block.
// Items go out from a queue through a clocked driver. Each accepted item is run
// through an in-bench Q16.16 solver, which keeps its own solution store, row sum
// and size setting. A clocked monitor compares each result, field by field, with
// the oldest expected solution.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE       = 60;       // well past the multiply-add

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    utbs_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    utbs_pkg::out_item_t m_data;
    logic                cfg_we;
    logic [10:0]         cfg_wdata;

    upper_triangular_back_substitution dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // stimulus side
    utbs_pkg::in_item_t coef_items[$];      // items not yet offered
    bit        solved_at_gen[utbs_pkg::MAX_UNKNOWNS];   // rows whose diagonal is queued
    int        gen_size;            // effective size as seen by the generator
    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        pressure_on;

    // solver copy kept by the bench
    logic signed [31:0]  sol_mem[utbs_pkg::MAX_UNKNOWNS];
    longint              row_sum;
    int                  eff_size;
    utbs_pkg::out_item_t solutions_due[$];

    int  mismatches;
    int  solutions_seen;
    int  cycle_cnt;
    int  hold_left;
    bit  hold_done;

    // ---------------------------------------------------------------- predictor
    function automatic longint sum_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (a >= 0 && b >= 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (a < 0 && b < 0 && s >= 0)  return 64'sh8000_0000_0000_0000;
        return s;
    endfunction

    function automatic longint diff_sat(longint a, longint b);
        longint s;
        s = a - b;
        if (a >= 0 && b < 0 && s < 0)  return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (a < 0 && b >= 0 && s >= 0) return 64'sh8000_0000_0000_0000;
        return s;
    endfunction

    // Works out the effect of one accepted item; queues a solution on a diagonal.
    task automatic solve_item(input utbs_pkg::in_item_t it);
        int                  r, c;
        longint              cf, rh, num;
        logic [63:0]         un, ud, q;
        bit                  neg;
        utbs_pkg::out_item_t res;
        r  = it.row_index;
        c  = it.column_index;
        cf = it.coefficient;
        rh = it.right_hand_side;
        if (r >= eff_size || c >= eff_size || c < r) return;
        if (c > r) begin
            row_sum = sum_sat(row_sum, cf * longint'(sol_mem[c]));
            return;
        end
        res = '0;
        res.solved_row = it.row_index;
        if (cf == 0) begin
            res.divide_by_zero = 1'b1;
        end else begin
            num = diff_sat(rh * 65536, row_sum);
            un  = num < 0 ? 64'd0 - 64'(num) : 64'(num);
            ud  = cf < 0 ? 64'd0 - 64'(cf) : 64'(cf);
            q   = un / ud;
            neg = (num < 0) != (cf < 0);
            if (neg) begin
                if (q > 64'h8000_0000) begin
                    res.saturated      = 1'b1;
                    res.solution_value = 32'sh8000_0000;
                end else begin
                    res.solution_value = 32'(64'd0 - q);
                end
            end else if (q > 64'h7FFF_FFFF) begin
                res.saturated      = 1'b1;
                res.solution_value = 32'sh7FFF_FFFF;
            end else begin
                res.solution_value = q[31:0];
            end
        end
        sol_mem[r] = res.solution_value;
        row_sum    = 0;
        solutions_due.push_back(res);
    endtask

    // ---------------------------------------------------------------- driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) solve_item(s_data);
            if (!s_valid || s_ready) begin
                if (coef_items.size() > 0 &&
                    $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= coef_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- back-pressure
    // long hold once, so the output register fills and s_ready drops
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (pressure_on && !hold_done) begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge aclk) begin
        utbs_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                solutions_seen++;
                if (solutions_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: row %0d value %h dz %b sat %b",
                                 m_data.solved_row, m_data.solution_value,
                                 m_data.divide_by_zero, m_data.saturated);
                end else begin
                    want = solutions_due.pop_front();
                    if (m_data.solved_row !== want.solved_row ||
                        m_data.solution_value !== want.solution_value ||
                        m_data.divide_by_zero !== want.divide_by_zero ||
                        m_data.saturated !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp row %0d val %h dz %b sat %b,",
                                      " got row %0d val %h dz %b sat %b"},
                                     want.solved_row, want.solution_value,
                                     want.divide_by_zero, want.saturated,
                                     m_data.solved_row, m_data.solution_value,
                                     m_data.divide_by_zero, m_data.saturated);
                    end
                end
            end
            if (hold_left > 0)
                m_ready <= 1'b0;
            else
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic add_item(input int r, input int c, input logic [31:0] cf,
                            input logic [31:0] rh);
        utbs_pkg::in_item_t it;
        it.row_index       = r[9:0];
        it.column_index    = c[9:0];
        it.coefficient     = cf;
        it.right_hand_side = rh;
        coef_items.push_back(it);
        if (r == c && r < gen_size) solved_at_gen[r] = 1'b1;
    endtask

    // Waits until the block has drained and is quiet.
    task automatic wait_idle();
        while (coef_items.size() > 0 || s_valid || solutions_due.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_size(input int v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[10:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        eff_size  = v > utbs_pkg::MAX_UNKNOWNS ? utbs_pkg::MAX_UNKNOWNS : v;
        gen_size  = eff_size;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coef(input bit diag);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return diag ? 32'h0 : $urandom();
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'(int'($urandom_range(0, 1 << 12)) - (1 << 11));
            default: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    function automatic logic [31:0] rand_rhs();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endfunction

    // Mostly well-formed row runs (last row first), some ignored noise.
    task automatic random_rows(input int n_items);
        int done_cnt, top, len, r, k, c, pick;
        done_cnt = 0;
        while (done_cnt < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 8 || gen_size == 0) begin
                // below the diagonal: ignored
                r = $urandom_range(1, 1023);
                add_item(r, $urandom_range(0, r - 1), $urandom(), $urandom());
            end else if (pick < 14 && gen_size < utbs_pkg::MAX_UNKNOWNS) begin
                // out of range row or column: ignored
                r = $urandom_range(gen_size, 1023);
                if ($urandom_range(0, 1))
                    add_item(r, $urandom_range(r, 1023), $urandom(), $urandom());
                else
                    add_item($urandom_range(0, gen_size - 1), r, $urandom(), $urandom());
            end else begin
                top = $urandom_range(0, gen_size - 1);
                len = $urandom_range(1, top + 1 < 8 ? top + 1 : 8);
                for (r = top; r > top - len; r--) begin
                    k = $urandom_range(0, 4);
                    repeat (k) begin
                        if (r < gen_size - 1) begin
                            c = $urandom_range(r + 1, gen_size - 1);
                            if (solved_at_gen[c]) begin
                                // odd off-diagonal item tagged with another row
                                if ($urandom_range(0, 9) == 0)
                                    add_item($urandom_range(0, c - 1), c, rand_coef(0),
                                             $urandom());
                                else
                                    add_item(r, c, rand_coef(0), $urandom());
                                done_cnt++;
                            end
                        end
                    end
                    add_item(r, r, rand_coef(1), rand_rhs());
                    done_cnt++;
                end
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        row_sum     = 0;
        eff_size    = utbs_pkg::MAX_UNKNOWNS;
        gen_size    = utbs_pkg::MAX_UNKNOWNS;
        tx_idle_pct = 25;
        rx_idle_pct = 87;
        pressure_on = 1'b0;
        hold_left   = 0;
        hold_done   = 1'b0;
        cycle_cnt   = 0;
        mismatches  = 0;
        solutions_seen = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_size(1024);
        // directed: extremes, zero divisor, clamps, ignored and mixed items
        add_item(1023, 1023, 32'h0001_0000, 32'h7FFF_FFFF);     // plain divide by 1.0
        add_item(1022, 1023, 32'h7FFF_FFFF, 32'h0);
        add_item(1022, 1022, 32'h8000_0000, 32'h8000_0000);     // extreme divisor
        add_item(1021, 1021, 32'h0, 32'h1234_5678);             // zero divisor
        add_item(1020, 1023, 32'h8000_0000, 32'h0);
        add_item(1020, 1022, 32'h7FFF_FFFF, 32'h0);
        add_item(1020, 1020, 32'h0000_0001, 32'h7FFF_FFFF);     // clamps high
        add_item(1019, 1019, 32'h0000_0001, 32'h8000_0000);     // clamps low
        add_item(1018, 1018, 32'hFFFF_FFFF, 32'h7FFF_FFFF);     // negative tiny divisor
        add_item(1017, 1017, 32'hFFFF_0000, 32'h8000_0000);     // -1.0 into min rhs
        add_item(1000, 3, 32'h7FFF_FFFF, 32'hFFFF_FFFF);        // below diagonal
        add_item(5, 1021, 32'h0002_0000, 32'h0);                // other row adds too
        add_item(1016, 1023, 32'h7FFF_FFFF, 32'h0);
        add_item(1016, 1016, 32'h0003_0000, 32'h0000_0000);
        add_item(0, 0, 32'h0001_8000, 32'hFFFF_FFFF);
        add_item(511, 511, 32'h0000_4000, 32'h5555_5555);
        add_item(510, 511, 32'hAAAA_AAAA, 32'h0);
        add_item(510, 1023, 32'h5555_5555, 32'h0);
        add_item(510, 510, 32'h0000_0100, 32'hAAAA_AAAA);
        random_rows(90);

        write_size(7);
        add_item(7, 7, 32'h0001_0000, 32'h0);                   // row out of range
        add_item(3, 9, 32'h0001_0000, 32'h0);                   // column out of range
        add_item(6, 6, 32'h0002_0000, 32'h0003_0000);
        random_rows(50);

        wait_idle();
        tx_idle_pct = 87;
        rx_idle_pct = 25;
        write_size(2047);
        random_rows(90);
        write_size(1);
        add_item(0, 0, 32'h0000_8000, 32'h0001_0000);
        random_rows(15);
        write_size(0);
        add_item(0, 0, 32'h0001_0000, 32'h0001_0000);           // size zero: ignored
        add_item(1023, 1023, 32'h0001_0000, 32'h0001_0000);

        wait_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_size(300);
        pressure_on = 1'b1;
        random_rows(100);
        write_size(1024);
        random_rows(40);

        wait_idle();
        if (mismatches == 0 && solutions_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
